// File: rtl/jsu_pkg.sv
// ============================================================================
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ============================================================================
package jsu_pkg;

    localparam int MaxResults = 5;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC,
        PH_HEX_A,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX_B,
        PH_SEQ,
        PH_CLOSED,
        PH_DROP
    } phase_t;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_UNTERM = 2'd1;
    localparam logic [1:0] ERR_ESCAPE = 2'd2;
    localparam logic [1:0] ERR_UTF8   = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] code;
    } result_t;

    typedef struct packed {
        logic [2:0]                     count;
        result_t [MaxResults-1:0]       ent;
    } burst_t;

    // bit 4 set when the byte is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

// File: rtl/jsu_decode.sv
// ============================================================================
// jsu_decode
// Parser state and per-byte decode: one input byte in, a burst of up to five
// results out, combinationally from the current state.
// ============================================================================
module jsu_decode (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      in_byte,
    input  logic            in_final,
    output jsu_pkg::burst_t burst
);
    import jsu_pkg::*;

    phase_t      phase_reg, phase_next, phase_mid;
    logic [20:0] acc_reg, acc_next;
    logic [15:0] high_reg, high_next;
    logic [1:0]  dcnt_reg, dcnt_next;
    logic [2:0]  slen_reg, slen_next;
    logic [2:0]  sseen_reg, sseen_next;

    logic [1:0]  err;
    logic [1:0]  fin_code;
    logic        closed;
    logic        emit;
    logic [20:0] cp;
    logic [4:0]  hex;
    logic [20:0] acc_hex;
    logic [20:0] acc_seq;
    logic [2:0]  seen_inc;
    logic [20:0] seq_min;
    logic [15:0] unit;

    logic [2:0]  dn;
    logic [7:0]  d [4];
    logic        tail_v;
    result_t     tail;

    assign hex      = hex_value(in_byte);
    assign acc_hex  = {acc_reg[16:0], hex[3:0]};
    assign acc_seq  = {acc_reg[14:0], in_byte[5:0]};
    assign seen_inc = sseen_reg + 3'd1;
    assign unit     = acc_hex[15:0];

    always_comb begin
        unique case (slen_reg)
            3'd2:    seq_min = 21'h000080;
            3'd3:    seq_min = 21'h000800;
            default: seq_min = 21'h010000;
        endcase
    end

    // next state
    always_comb begin
        phase_mid  = phase_reg;
        acc_next   = acc_reg;
        high_next  = high_reg;
        dcnt_next  = dcnt_reg;
        slen_next  = slen_reg;
        sseen_next = sseen_reg;
        err        = ERR_NONE;
        closed     = 1'b0;
        emit       = 1'b0;
        cp         = 21'd0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (in_byte == CH_QUOTE) phase_mid = PH_STR;
                else err = ERR_UNTERM;
            end
            PH_STR: begin
                priority if (in_byte == CH_QUOTE) begin
                    closed = 1'b1;
                end else if (in_byte == CH_BSLASH) begin
                    phase_mid = PH_ESC;
                end else if (in_byte < 8'h20) begin
                    err = ERR_UNTERM;
                end else if (in_byte < 8'h80) begin
                    emit = 1'b1;
                    cp   = {13'd0, in_byte};
                end else if (in_byte[7:5] == 3'b110) begin
                    acc_next   = {16'd0, in_byte[4:0]};
                    slen_next  = 3'd2;
                    sseen_next = 3'd1;
                    phase_mid  = PH_SEQ;
                end else if (in_byte[7:4] == 4'b1110) begin
                    acc_next   = {17'd0, in_byte[3:0]};
                    slen_next  = 3'd3;
                    sseen_next = 3'd1;
                    phase_mid  = PH_SEQ;
                end else if (in_byte[7:3] == 5'b11110) begin
                    acc_next   = {18'd0, in_byte[2:0]};
                    slen_next  = 3'd4;
                    sseen_next = 3'd1;
                    phase_mid  = PH_SEQ;
                end else begin
                    err = ERR_UTF8;
                end
            end
            PH_ESC: begin
                phase_mid = PH_STR;
                emit      = 1'b1;
                unique case (in_byte)
                    CH_QUOTE:  cp = {13'd0, CH_QUOTE};
                    CH_BSLASH: cp = {13'd0, CH_BSLASH};
                    8'h2F:     cp = 21'h2F;   // '/'
                    8'h62:     cp = 21'h08;   // 'b'
                    8'h66:     cp = 21'h0C;   // 'f'
                    8'h6E:     cp = 21'h0A;   // 'n'
                    8'h72:     cp = 21'h0D;   // 'r'
                    8'h74:     cp = 21'h09;   // 't'
                    CH_U: begin
                        emit      = 1'b0;
                        acc_next  = 21'd0;
                        dcnt_next = 2'd0;
                        phase_mid = PH_HEX_A;
                    end
                    default: begin
                        emit = 1'b0;
                        err  = ERR_ESCAPE;
                    end
                endcase
            end
            PH_HEX_A, PH_HEX_B: begin
                if (!hex[4]) begin
                    err = ERR_ESCAPE;
                end else begin
                    acc_next = acc_hex;
                    if (dcnt_reg != 2'd3) begin
                        dcnt_next = dcnt_reg + 2'd1;
                    end else begin
                        dcnt_next = 2'd0;
                        if (phase_reg == PH_HEX_A) begin
                            priority if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                                high_next = unit;
                                phase_mid = PH_WANT_BS;
                            end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                                err = ERR_ESCAPE;
                            end else begin
                                emit      = 1'b1;
                                cp        = {5'd0, unit};
                                phase_mid = PH_STR;
                            end
                        end else begin
                            if (unit < 16'hDC00 || unit > 16'hDFFF ||
                                high_reg < 16'hD800 || high_reg > 16'hDBFF) begin
                                err = ERR_ESCAPE;
                            end else begin
                                emit      = 1'b1;
                                cp        = 21'h010000 + {1'b0, high_reg[9:0], unit[9:0]};
                                phase_mid = PH_STR;
                            end
                        end
                    end
                end
            end
            PH_WANT_BS: begin
                if (in_byte == CH_BSLASH) phase_mid = PH_WANT_U;
                else err = ERR_ESCAPE;
            end
            PH_WANT_U: begin
                if (in_byte == CH_U) begin
                    acc_next  = 21'd0;
                    dcnt_next = 2'd0;
                    phase_mid = PH_HEX_B;
                end else begin
                    err = ERR_ESCAPE;
                end
            end
            PH_SEQ: begin
                if (in_byte[7:6] != 2'b10) begin
                    err = ERR_UTF8;
                end else begin
                    acc_next   = acc_seq;
                    sseen_next = seen_inc;
                    if (seen_inc >= slen_reg) begin
                        if (acc_seq < seq_min || acc_seq > 21'h10FFFF ||
                            (acc_seq >= 21'h00D800 && acc_seq <= 21'h00DFFF)) begin
                            err = ERR_UTF8;
                        end else begin
                            emit      = 1'b1;
                            cp        = acc_seq;
                            phase_mid = PH_STR;
                        end
                    end
                end
            end
            default: ;   // closed or dropping: ignore bytes
        endcase
    end

    // buffer-end error code, from where the string was left
    always_comb begin
        unique case (phase_mid)
            PH_STR, PH_ESC:                             fin_code = ERR_UNTERM;
            PH_HEX_A, PH_HEX_B, PH_WANT_BS, PH_WANT_U:  fin_code = ERR_ESCAPE;
            PH_SEQ:                                     fin_code = ERR_UTF8;
            default:                                    fin_code = ERR_NONE;
        endcase
    end

    always_comb begin
        priority if (err != ERR_NONE) phase_next = PH_DROP;
        else if (closed)              phase_next = PH_CLOSED;
        else                          phase_next = phase_mid;
        if (in_final) phase_next = PH_IDLE;
    end

    // outputs: UTF-8 encode plus at most one trailing status result
    always_comb begin
        d[0] = 8'd0;
        d[1] = 8'd0;
        d[2] = 8'd0;
        d[3] = 8'd0;
        if (!emit) begin
            dn = 3'd0;
        end else if (cp <= 21'h7F) begin
            dn   = 3'd1;
            d[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            dn   = 3'd2;
            d[0] = {3'b110, cp[10:6]};
            d[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            dn   = 3'd3;
            d[0] = {4'b1110, cp[15:12]};
            d[1] = {2'b10, cp[11:6]};
            d[2] = {2'b10, cp[5:0]};
        end else begin
            dn   = 3'd4;
            d[0] = {5'b11110, cp[20:18]};
            d[1] = {2'b10, cp[17:12]};
            d[2] = {2'b10, cp[11:6]};
            d[3] = {2'b10, cp[5:0]};
        end

        tail_v = 1'b1;
        priority if (err != ERR_NONE) begin
            tail = '{kind: KIND_ERROR, data: 8'd0, code: err};
        end else if (closed) begin
            tail = '{kind: KIND_DONE, data: 8'd0, code: ERR_NONE};
        end else if (in_final && fin_code != ERR_NONE) begin
            tail = '{kind: KIND_ERROR, data: 8'd0, code: fin_code};
        end else begin
            tail_v = 1'b0;
            tail   = '{kind: KIND_DATA, data: 8'd0, code: ERR_NONE};
        end

        burst.count = dn + {2'd0, tail_v};
        for (int i = 0; i < MaxResults; i++) begin
            if (3'(i) < dn) begin
                burst.ent[i] = '{kind: KIND_DATA, data: d[i % 4], code: ERR_NONE};
            end else if (3'(i) == dn) begin
                burst.ent[i] = tail;
            end else begin
                burst.ent[i] = '{kind: KIND_DATA, data: 8'd0, code: ERR_NONE};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= 21'd0;
            high_reg  <= 16'd0;
            dcnt_reg  <= 2'd0;
            slen_reg  <= 3'd0;
            sseen_reg <= 3'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            if (in_final) begin
                acc_reg   <= 21'd0;
                high_reg  <= 16'd0;
                dcnt_reg  <= 2'd0;
                slen_reg  <= 3'd0;
                sseen_reg <= 3'd0;
            end else begin
                acc_reg   <= acc_next;
                high_reg  <= high_next;
                dcnt_reg  <= dcnt_next;
                slen_reg  <= slen_next;
                sseen_reg <= sseen_next;
            end
        end
    end

endmodule

// File: rtl/json_string_unescaper_unit.sv
// ============================================================================
// json_string_unescaper_unit
// Streaming decoder for one JSON string literal with UTF-8 checking.
// ============================================================================
// Slave channel: one raw byte per transfer, s_tlast marks the last byte of
// the buffer, which must start with the opening quote. Master channel: one
// result per transfer: a decoded UTF-8 byte, a done marker for the closing
// quote, or an error with its code; m_tlast marks the last result caused by
// a given input byte.
// The results of a byte pass through the input register, then through the
// result register, which is loaded from the decode logic.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver does not stall; a byte giving more results (up to five)
// holds the next byte until the single-result master channel drains them.
// The input register takes a new byte while results still wait.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to waiting for an opening quote. When the receiver stalls, the
// current result holds and the input side fills its one register and stops.
// ============================================================================
module json_string_unescaper_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [9:8] error_code, rest zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast
);
    import jsu_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_final_reg;

    result_t    ent_reg [MaxResults];
    logic [2:0] cnt_reg;

    burst_t     burst;
    logic       out_free;
    logic       step;
    logic       take;

    assign take     = m_tvalid && m_tready;
    assign out_free = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_tready);
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;

    jsu_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .in_byte  (in_byte_reg),
        .in_final (in_final_reg),
        .burst    (burst)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_final_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else if (step) begin
            cnt_reg <= burst.count;
        end else if (take) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    // results leave from entry 0; the rest shift down on each transfer
    always_ff @(posedge aclk) begin
        if (step) begin
            for (int i = 0; i < MaxResults; i++) begin
                ent_reg[i] <= burst.ent[i];
            end
        end else if (take) begin
            for (int i = 0; i < MaxResults - 1; i++) begin
                ent_reg[i] <= ent_reg[i+1];
            end
        end
    end

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tlast  = (cnt_reg == 3'd1);
    assign m_tdata  = {6'd0, ent_reg[0].code, ent_reg[0].data};
    assign m_tuser  = ent_reg[0].kind;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(MaxResults))
        else $error("result count out of range");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("pending result changed under stall");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_final_reg))
        else $error("input register lost a byte");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[9:8] != ERR_NONE)
        else $error("error result without code");

    a_data_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_ERROR |-> m_tdata[9:8] == ERR_NONE)
        else $error("non-error result with code");

endmodule
